/* src/afd_pkg.sv */
// Shared types and constants for the accelerometer magnitude fall detector.
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

    // Averaging window length, in samples.
    localparam int WINDOW    = 10;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int SUMSQ_W   = 32;
    localparam int REM_W     = MAG_W + 1;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W   = $clog2(WINDOW * 65535 + 1);
    localparam int WIN_W     = 7;
    localparam int SQRT_STEPS = SUMSQ_W / 2;
    localparam int CNT_W     = $clog2(SQRT_STEPS);
    localparam int NUM_AXES  = 3;

    // Floor reciprocal of the window; quotient estimate is low by at most one.
    localparam logic [TOTAL_W:0] RECIP = (TOTAL_W + 1)'((64'd1 << TOTAL_W) / WINDOW);

    localparam logic [MAG_W-1:0] MAG_MAX       = 16'd56755;
    localparam logic [15:0]      THRESH_RESET  = 16'd410;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } t_accel_in;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] smoothed_magnitude;
        logic             fall_detected;
    } t_accel_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_SQRT,
        S_UPD,
        S_DIV,
        S_FIX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [1:0] axis_sel;
        logic       sqrt_step;
        logic       update;
        logic       div;
        logic       fix;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* src/afd_ctrl.sv */
// Sequencer for the fall detector: steps one request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module afd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  afd_pkg::t_status i_status,
    output afd_pkg::t_cmd   o_cmd
);
    import afd_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               sqr_last, sqrt_last;

    assign sqr_last  = (r_cnt == CNT_W'(NUM_AXES - 1));
    assign sqrt_last = (r_cnt == CNT_W'(SQRT_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQR;
            end
            S_SQR: begin
                if (sqr_last) n_state = S_SQRT;
                else          n_cnt   = r_cnt + 1'b1;
            end
            S_SQRT: begin
                if (sqrt_last) n_state = S_UPD;
                else           n_cnt   = r_cnt + 1'b1;
            end
            S_UPD:   n_state = S_DIV;
            S_DIV:   n_state = S_FIX;
            S_FIX:   n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQR: begin
                o_cmd.sq_step  = 1'b1;
                o_cmd.axis_sel = r_cnt[1:0];
            end
            S_SQRT:  o_cmd.sqrt_step = 1'b1;
            S_UPD:   o_cmd.update    = 1'b1;
            S_DIV:   o_cmd.div       = 1'b1;
            S_FIX:   o_cmd.fix       = 1'b1;
            S_OUT:   o_cmd.out_load  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/afd_datapath.sv */
// Datapath: squares, bit-serial square root, window ring, average and flag.
`timescale 1ns / 1ps
`default_nettype none

module afd_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  afd_pkg::t_accel_in  i_in_data,
    input  afd_pkg::t_cmd       i_cmd,
    output afd_pkg::t_status    o_status,
    input  wire                 i_cfg_we,
    input  wire [15:0]          i_cfg_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output afd_pkg::t_accel_out o_out_data
);
    import afd_pkg::*;

    logic [SAMPLE_W-1:0] r_ax, r_ay, r_az;
    logic [SUMSQ_W-1:0]  r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_root;
    logic [MAG_W-1:0]    r_ring [WINDOW];
    logic [SLOT_W-1:0]   r_slot;
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  r_quot;
    logic [MAG_W-1:0]    r_avg;
    logic [15:0]         r_thresh;
    logic                r_out_valid;
    t_accel_out          r_out;

    logic [SAMPLE_W-1:0]     sq_op;
    logic [SUMSQ_W-1:0]      sq_prod;
    logic [REM_W+1:0]        rem_sh, trial, diff;
    logic [2*TOTAL_W:0]      div_prod;
    logic [TOTAL_W+WIN_W-1:0] back;
    logic [TOTAL_W-1:0]      rem_div, n_total;

    function automatic logic [SAMPLE_W-1:0] f_abs(input logic signed [SAMPLE_W-1:0] v);
        f_abs = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        case (i_cmd.axis_sel)
            AXIS_X:  sq_op = r_ax;
            AXIS_Y:  sq_op = r_ay;
            AXIS_Z:  sq_op = r_az;
            default: sq_op = '0;
        endcase
    end
    assign sq_prod = sq_op * sq_op;

    // restoring square root, two radicand bits per step
    assign rem_sh = {r_rem, r_rad[SUMSQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign diff   = rem_sh - trial;

    assign n_total  = r_total - TOTAL_W'(r_ring[r_slot]) + TOTAL_W'(r_root);
    assign div_prod = r_total * RECIP;
    assign back     = r_quot * WIN_W'(WINDOW);
    assign rem_div  = r_total - TOTAL_W'(back);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= f_abs(i_in_data.accel_x);
            r_ay <= f_abs(i_in_data.accel_y);
            r_az <= f_abs(i_in_data.accel_z);
        end
        if (i_cmd.load) begin
            r_rad  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad <= r_rad + sq_prod;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[SUMSQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= diff[REM_W-1:0];
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div) r_quot <= div_prod[2*TOTAL_W-1:TOTAL_W];
        if (i_cmd.fix) begin
            if (rem_div >= TOTAL_W'(WINDOW)) r_avg <= MAG_W'(r_quot + 1'b1);
            else                             r_avg <= MAG_W'(r_quot);
        end
        if (i_cmd.out_load) begin
            r_out.magnitude          <= r_root;
            r_out.smoothed_magnitude <= r_avg;
            r_out.fall_detected      <= (r_avg < r_thresh);
        end
    end

    // window state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) r_ring[i] <= '0;
            r_slot      <= '0;
            r_total     <= '0;
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_ring[r_slot] <= r_root;
                r_total        <= n_total;
                if (r_slot == SLOT_W'(WINDOW - 1)) r_slot <= '0;
                else                               r_slot <= r_slot + 1'b1;
            end
            if (i_cfg_we) r_thresh <= i_cfg_data;
            if (i_cmd.out_load)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

/* src/accel_magnitude_fall_detector_top.sv */
// Top level of the accelerometer magnitude fall detector.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed three-axis sample (4096 counts per g) per request and returns
// one result: the floor square root of x^2+y^2+z^2, the floor average of the last
// 10 magnitudes (slots start at zero, so early averages are pulled low), and a
// fall flag set when that average is strictly below the fall threshold (reset 410).
// Each request runs through the sequencer states in order: summing the squares
// on one shared multiplier, the bit-serial square root (two radicand bits per
// step), the ring/total update, a reciprocal divide and its correction, and the
// load of the output register, which waits while the previous result is unread. The sequencer handles
// one request at a time; the next one is taken as soon as the previous result
// sits in the output register, even if the sink has not yet taken it.
// Threshold writes take effect at once and should be made while idle.

module accel_magnitude_fall_detector_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // sample requests
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  afd_pkg::t_accel_in  i_in_data,
    // results
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output afd_pkg::t_accel_out o_out_data,
    // fall threshold register
    input  wire                 i_cfg_we,
    input  wire [15:0]          i_cfg_data
);
    import afd_pkg::*;

    t_cmd    cmd;
    t_status status;

    afd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    afd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // an accepted request closes the input until its result is loaded
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened right after accept");

    // a new result only appears after the sequencer has been busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> !$past(o_in_ready))
        else $error("result appeared without work");

    // magnitude and its average never exceed the largest possible root
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.magnitude <= MAG_MAX &&
                         o_out_data.smoothed_magnitude <= MAG_MAX))
        else $error("magnitude out of range");

endmodule

`default_nettype wire
